[rtl/cbs_pkg.sv]
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared widths, command and status types, and the binomial table for the
// cardinal B-spline evaluator.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int IN_W          = 21;
  localparam int OUT_W         = 26;
  localparam int ORD_W         = 4;
  localparam int IN_FRAC       = 16;
  localparam int WORK_FRAC     = 28;
  localparam int C_W           = 10;
  localparam int CH_W          = 24;
  localparam int DIV_STEP      = 8;
  localparam int BINOM_N       = 13;
  localparam int MAX_ORDER_DEF = 8;
  localparam int OUT_FRAC_DEF  = 24;

  localparam logic [ORD_W-1:0] ORDER_RESET = 4'd4;

  // Bits of the scaled power register: integer bits bound by max d^j / j!.
  function automatic int p_width(int max_order);
    longint num;
    longint den;
    int     best;
    int     b;
    num  = 1;
    den  = 1;
    best = 1;
    for (int j = 1; j < max_order; j++) begin
      num = num * max_order;
      den = den * j;
      b   = 0;
      while (num >= (den << b)) b++;
      if (b > best) best = b;
    end
    return best + WORK_FRAC;
  endfunction

  function automatic int d_width(int max_order);
    return IN_FRAC + $clog2(max_order);
  endfunction

  function automatic int num_chunks(int max_order);
    return (p_width(max_order) + CH_W - 1) / CH_W;
  endfunction

  function automatic int div_cycles(int max_order);
    return (p_width(max_order) + d_width(max_order) - IN_FRAC + DIV_STEP - 1) / DIV_STEP;
  endfunction

  function automatic logic [BINOM_N*BINOM_N*C_W-1:0] binom_table();
    logic [BINOM_N*BINOM_N*C_W-1:0] tbl;
    int row [BINOM_N];
    tbl = '0;
    for (int k = 0; k < BINOM_N; k++) row[k] = 0;
    row[0] = 1;
    for (int n = 0; n < BINOM_N; n++) begin
      for (int k = n; k > 0; k--) row[k] = row[k] + row[k-1];
      for (int k = 0; k < BINOM_N; k++) tbl[(n*BINOM_N+k)*C_W +: C_W] = C_W'(row[k]);
    end
    return tbl;
  endfunction

  localparam logic [BINOM_N*BINOM_N*C_W-1:0] BINOM_TBL = binom_table();

  function automatic logic [C_W-1:0] binom(logic [ORD_W-1:0] n, logic [ORD_W-1:0] k);
    return BINOM_TBL[(int'(n)*BINOM_N + int'(k))*C_W +: C_W];
  endfunction

  typedef struct packed {
    logic             load_t;
    logic             start_term;
    logic             mul_en;
    logic             mul_first;
    logic             mul_use_c;
    logic             div_en;
    logic             div_first;
    logic             div_last;
    logic             acc_en;
    logic             load_out;
    logic [ORD_W-1:0] order;
    logic [ORD_W-1:0] term_idx;
    logic [ORD_W-1:0] pow_idx;
  } cbs_cmd_t;

  typedef struct packed {
    logic beyond;
    logic below_knot;
  } cbs_sts_t;

endpackage

[rtl/cardinal_bspline_eval.sv]
// ----------------------------------------------------------------------------
// cardinal_bspline_eval
// Cardinal B-spline of a configured order at one point per transaction, in
// truncated-power form, on one shared multiplier and a small divider.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------
//   cfg     | in        | cfg_valid/cfg_ready | cfg_spline_order [3:0]
//   in      | in        | in_valid/in_ready   | in_point [20:0] signed
//   out     | out       | out_valid/out_ready | out_spline_value [25:0] signed
//
// A point at or above the order skips the terms and gives zero; otherwise each
// knot at or below the point adds one term: the distance is raised to the power
// n-1 by steps, each a chunked multiply by the distance and a division by the
// step index, and is then multiplied by the binomial coefficient.
// Reset is synchronous, active low; the order register resets to 4.
// A held result stalls only the last state; the next transaction is taken.
// ----------------------------------------------------------------------------
module cardinal_bspline_eval
  import cbs_pkg::*;
#(
  parameter int MAX_ORDER     = MAX_ORDER_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [ORD_W-1:0]        cfg_spline_order,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  in_point,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_spline_value
);

  logic [ORD_W-1:0] spline_order_r;
  cbs_cmd_t         cmd;
  cbs_sts_t         sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spline_order_r <= ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      spline_order_r <= cfg_spline_order;
    end
  end

  cbs_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_order (spline_order_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbs_dpath #(
    .MAX_ORDER     (MAX_ORDER),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_dpath (
    .clk              (clk),
    .in_point         (in_point),
    .cmd              (cmd),
    .sts              (sts),
    .out_spline_value (out_spline_value)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && sts.beyond) |=> (out_spline_value == '0))
    else $error("point at or above the order gave a nonzero result");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_t, cmd.mul_en, cmd.div_en, cmd.acc_en, cmd.load_out}))
    else $error("datapath given overlapping commands");

endmodule

[rtl/cbs_ctrl.sv]
// ----------------------------------------------------------------------------
// cbs_ctrl
// Sequencer: walks terms, power steps, multiplier chunks and divider cycles,
// and owns both handshakes of the data channels.
// ----------------------------------------------------------------------------
module cbs_ctrl
  import cbs_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ORD_W-1:0] cfg_order,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  cbs_sts_t         sts,
  output cbs_cmd_t         cmd
);

  localparam int NCH   = num_chunks(MAX_ORDER);
  localparam int DVN   = div_cycles(MAX_ORDER);
  localparam int CNT_W = $clog2(((NCH > DVN) ? NCH : DVN) + 1);

  localparam logic [CNT_W-1:0] CNT_MUL = CNT_W'(NCH - 1);
  localparam logic [CNT_W-1:0] CNT_DIV = CNT_W'(DVN - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_TERM  = 3'd2;
  localparam logic [2:0] S_MULP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_MULC  = 3'd5;
  localparam logic [2:0] S_ACC   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [ORD_W-1:0] n_r, n_nxt;
  logic [ORD_W-1:0] i_r, i_nxt;
  logic [ORD_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ORD_W-1:0] order_clamped;
  logic             out_free;

  always_comb begin
    if (cfg_order == '0) begin
      order_clamped = ORD_W'(1);
    end else if (cfg_order > ORD_W'(MAX_ORDER)) begin
      order_clamped = ORD_W'(MAX_ORDER);
    end else begin
      order_clamped = cfg_order;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.order     = n_r;
    cmd.term_idx  = i_r;
    cmd.pow_idx   = j_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_t = 1'b1;
          n_nxt      = order_clamped;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        i_nxt = '0;
        if (sts.beyond) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        if (sts.below_knot) begin
          state_nxt = S_FIN;
        end else begin
          cmd.start_term = 1'b1;
          j_nxt          = ORD_W'(1);
          cnt_nxt        = CNT_MUL;
          state_nxt      = (n_r == ORD_W'(1)) ? S_MULC : S_MULP;
        end
      end
      S_MULP: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_first = (cnt_r == CNT_MUL);
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_DIV;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DIV: begin
        cmd.div_en    = 1'b1;
        cmd.div_first = (cnt_r == CNT_DIV);
        cmd.div_last  = (cnt_r == '0);
        if (cnt_r == '0) begin
          cnt_nxt = CNT_MUL;
          if (j_r == n_r - ORD_W'(1)) begin
            state_nxt = S_MULC;
          end else begin
            j_nxt     = j_r + ORD_W'(1);
            state_nxt = S_MULP;
          end
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_MULC: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_use_c = 1'b1;
        cmd.mul_first = (cnt_r == CNT_MUL);
        if (cnt_r == '0) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (i_r == n_r) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt     = i_r + ORD_W'(1);
          state_nxt = S_TERM;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= ORDER_RESET;
      i_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/cbs_dpath.sv]
// ----------------------------------------------------------------------------
// cbs_dpath
// Datapath: shifted point, chunked shared multiplier, radix-2 divider by the
// power index, signed term accumulator, output truncation and saturation.
// ----------------------------------------------------------------------------
module cbs_dpath
  import cbs_pkg::*;
#(
  parameter int MAX_ORDER     = MAX_ORDER_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
  input  logic                    clk,
  input  logic signed [IN_W-1:0]  in_point,
  input  cbs_cmd_t                cmd,
  output cbs_sts_t                sts,
  output logic signed [OUT_W-1:0] out_spline_value
);

  localparam int D_W   = d_width(MAX_ORDER);
  localparam int P_W   = p_width(MAX_ORDER);
  localparam int MB_W  = (D_W > C_W) ? D_W : C_W;
  localparam int NCH   = num_chunks(MAX_ORDER);
  localparam int PP_W  = NCH * CH_W;
  localparam int PR_W  = PP_W + MB_W;
  localparam int X_W   = P_W + D_W - IN_FRAC;
  localparam int DVN   = div_cycles(MAX_ORDER);
  localparam int DV_W  = DVN * DIV_STEP;
  localparam int T_W   = P_W + C_W;
  localparam int S_W   = T_W + 5;
  localparam int UP    = (OUT_FRAC_BITS > WORK_FRAC) ? (OUT_FRAC_BITS - WORK_FRAC) : 0;
  localparam int DN    = (WORK_FRAC > OUT_FRAC_BITS) ? (WORK_FRAC - OUT_FRAC_BITS) : 0;
  localparam int CV_W  = S_W + UP;
  localparam int KN_W  = IN_W + 1;
  localparam int KPAD  = KN_W - ORD_W - IN_FRAC;

  localparam logic [P_W-1:0] P_ONE = P_W'(1) << WORK_FRAC;
  localparam logic signed [CV_W-1:0] SAT_HI =
    $signed({{(CV_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
  localparam logic signed [CV_W-1:0] SAT_LO =
    $signed({{(CV_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}});

  logic signed [IN_W-1:0]  t_r;
  logic        [D_W-1:0]   d_r;
  logic        [P_W-1:0]   p_r;
  logic        [PP_W-1:0]  sh_r;
  logic        [PR_W-1:0]  acc_r;
  logic        [DV_W-1:0]  q_r;
  logic        [ORD_W-1:0] rem_r;
  logic signed [S_W-1:0]   sum_r;
  logic signed [OUT_W-1:0] out_r;

  logic signed [KN_W-1:0]  t_ext, knot_i, knot_n, d_full;
  logic        [PP_W-1:0]  chunk_src, sh_nxt;
  logic        [CH_W-1:0]  chunk;
  logic        [MB_W-1:0]  mul_b;
  logic [CH_W+MB_W-1:0]    prod;
  logic        [PR_W-1:0]  acc_nxt;
  logic        [DV_W-1:0]  div_q;
  logic        [ORD_W:0]   div_r;
  logic signed [S_W-1:0]   term_ext, sum_nxt;
  logic signed [CV_W-1:0]  cv_ext, cv;
  logic signed [OUT_W-1:0] out_nxt;

  assign t_ext  = KN_W'(t_r);
  assign knot_i = $signed({{KPAD{1'b0}}, cmd.term_idx, {IN_FRAC{1'b0}}});
  assign knot_n = $signed({{KPAD{1'b0}}, cmd.order, {IN_FRAC{1'b0}}});
  assign d_full = t_ext - knot_i;

  assign sts.beyond     = (t_ext >= knot_n);
  assign sts.below_knot = (t_ext < knot_i);

  assign chunk_src = cmd.mul_first ? PP_W'(p_r) : sh_r;
  assign chunk     = chunk_src[PP_W-1 -: CH_W];
  assign sh_nxt    = chunk_src << CH_W;
  assign mul_b     = cmd.mul_use_c ? MB_W'(binom(cmd.order, cmd.term_idx)) : MB_W'(d_r);
  assign prod      = chunk * mul_b;
  assign acc_nxt   = (cmd.mul_first ? '0 : (acc_r << CH_W)) + PR_W'(prod);

  always_comb begin
    div_q = cmd.div_first ? DV_W'(acc_r[IN_FRAC +: X_W]) : q_r;
    div_r = cmd.div_first ? '0 : {1'b0, rem_r};
    for (int b = 0; b < DIV_STEP; b++) begin
      div_r = {div_r[ORD_W-1:0], div_q[DV_W-1]};
      div_q = {div_q[DV_W-2:0], 1'b0};
      if (div_r >= {1'b0, cmd.pow_idx}) begin
        div_r    = div_r - {1'b0, cmd.pow_idx};
        div_q[0] = 1'b1;
      end
    end
  end

  assign term_ext = $signed(S_W'(acc_r[T_W-1:0]));

  always_comb begin
    sum_nxt = sum_r;
    if (cmd.load_t) begin
      sum_nxt = '0;
    end else if (cmd.acc_en) begin
      sum_nxt = cmd.term_idx[0] ? (sum_r - term_ext) : (sum_r + term_ext);
    end
  end

  always_comb begin
    cv_ext = CV_W'(sum_r);
    cv     = (cv_ext <<< UP) >>> DN;
    if (cv > SAT_HI) begin
      out_nxt = SAT_HI[OUT_W-1:0];
    end else if (cv < SAT_LO) begin
      out_nxt = SAT_LO[OUT_W-1:0];
    end else begin
      out_nxt = cv[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_t) t_r <= in_point;
    if (cmd.start_term) begin
      d_r <= d_full[D_W-1:0];
      p_r <= P_ONE;
    end else if (cmd.div_last) begin
      p_r <= div_q[P_W-1:0];
    end
    if (cmd.mul_en) begin
      sh_r  <= sh_nxt;
      acc_r <= acc_nxt;
    end
    if (cmd.div_en) begin
      q_r   <= div_q;
      rem_r <= div_r[ORD_W-1:0];
    end
    sum_r <= sum_nxt;
    if (cmd.load_out) out_r <= out_nxt;
  end

  assign out_spline_value = out_r;

endmodule

[bench/cardinal_bspline_eval_tb.sv]
// ----------------------------------------------------------------------------
// cardinal_bspline_eval_tb
// Self-checking bench for the cardinal B-spline evaluator. A scoreboard class
// predicts each spline value from the accepted point and the order in force,
// and compares every result in arrival order. Directed points hit the knots,
// the ends of the point range and the order clamps. Random points then run
// under a series of order settings, with random gaps on both channels outside the quiet phases.
// ----------------------------------------------------------------------------
module cardinal_bspline_eval_tb;
  import cbs_pkg::*;

  localparam int PHASES      = 13;
  localparam int PHASE_ITEMS = 142;
  localparam int TAIL_CYCLES = 500;

  class spline_scoreboard;
    logic signed [OUT_W-1:0] expected_values[$];
    int mismatches;
    int checked;
    int accepted;

    function new();
      mismatches = 0;
      checked    = 0;
      accepted   = 0;
    endfunction

    function logic signed [OUT_W-1:0] spline_at(logic signed [IN_W-1:0] t,
                                                 logic [ORD_W-1:0] ord);
      longint          tv;
      longint          acc;
      longint          v;
      longint          hi;
      longint          lo;
      longint          term;
      longint unsigned c;
      longint unsigned d;
      longint unsigned p;
      int              n;
      int              i;
      int              j;
      tv = t;
      n  = ord;
      if (n < 1) n = 1;
      if (n > MAX_ORDER_DEF) n = MAX_ORDER_DEF;
      if (tv >= (longint'(n) <<< IN_FRAC)) return '0;
      acc = 0;
      c   = 1;
      for (i = 0; i <= n; i++) begin
        if (tv >= (longint'(i) <<< IN_FRAC)) begin
          d = tv - (longint'(i) <<< IN_FRAC);
          p = 64'd1 << WORK_FRAC;
          for (j = 1; j < n; j++) p = (p * d) / (longint'(j) << IN_FRAC);
          term = c * p;
          if (i % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
        c = c * longint'(n - i) / longint'(i + 1);
      end
      if (OUT_FRAC_DEF >= WORK_FRAC) v = acc <<< (OUT_FRAC_DEF - WORK_FRAC);
      else v = acc >>> (WORK_FRAC - OUT_FRAC_DEF);
      hi = (longint'(1) <<< (OUT_W - 1)) - 1;
      lo = -(longint'(1) <<< (OUT_W - 1));
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return OUT_W'(v);
    endfunction

    function void note_point(logic signed [IN_W-1:0] t, logic [ORD_W-1:0] ord);
      expected_values.push_back(spline_at(t, ord));
      accepted++;
    endfunction

    function void check_value(logic signed [OUT_W-1:0] actual);
      logic signed [OUT_W-1:0] want;
      checked++;
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", actual);
        return;
      end
      want = expected_values.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: spline_value expected %0d, got %0d", checked, want, actual);
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [ORD_W-1:0]        cfg_spline_order;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [IN_W-1:0]  in_point;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] out_spline_value;

  logic [ORD_W-1:0] order_reg;
  logic [15:0]      orders_written;
  bit               quiet;
  int               order_plan [11] = '{1, 8, 0, 15, 2, 3, 5, 6, 7, 9, 4};
  spline_scoreboard sb;

  cardinal_bspline_eval dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_spline_order (cfg_spline_order),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_point         (in_point),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_spline_value (out_spline_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #80_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_point(input logic signed [IN_W-1:0] p);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_point = p;
    do @(posedge clk); while (!in_ready);
    sb.note_point(p, order_reg);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_order(input logic [ORD_W-1:0] ord);
    drain();
    @(negedge clk);
    cfg_valid        = 1'b1;
    cfg_spline_order = ord;
    do @(posedge clk); while (!cfg_ready);
    order_reg           = ord;
    orders_written[ord] = 1'b1;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [IN_W-1:0] pick_point(logic [ORD_W-1:0] ord);
    int n;
    int sel;
    int span;
    n = ord;
    if (n < 1) n = 1;
    if (n > MAX_ORDER_DEF) n = MAX_ORDER_DEF;
    sel = $urandom_range(0, 99);
    if (sel < 10) return IN_W'($urandom);
    if (sel < 30) return IN_W'(($urandom_range(0, n + 1) << IN_FRAC) + $urandom_range(0, 4) - 2);
    if (sel < 35) return IN_W'(-int'($urandom_range(1, 1 << 18)));
    span = (n + 1) << IN_FRAC;
    return IN_W'(int'($urandom_range(0, span)) - (1 << (IN_FRAC - 1)));
  endfunction

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int stall;
      stall = quiet ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_value(out_spline_value);
    end
  end

  initial begin
    int ph;
    int k;
    int failures;
    sb               = new();
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_spline_order = ORDER_RESET;
    in_valid         = 1'b0;
    in_point         = '0;
    order_reg        = ORDER_RESET;
    orders_written   = '0;
    quiet            = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    send_point(0);
    send_point(1);
    send_point(-1);
    send_point(21'sh08000);
    send_point(21'sh10000);
    send_point(21'sh20000);
    send_point(21'sh3FFFF);
    send_point(21'sh40000);
    send_point(21'sh0FFFFF);
    send_point(-21'sh100000);
    set_order(1);
    send_point(0);
    send_point(21'sh0FFFF);
    send_point(21'sh10000);
    send_point(-1);
    set_order(0);
    send_point(21'sh08000);
    send_point(21'sh10000);
    set_order(8);
    send_point(21'sh40000);
    send_point(21'sh7FFFF);
    send_point(1);
    set_order(15);
    send_point(21'sh40000);
    send_point(21'sh304D2);
    set_order(2);
    send_point(21'sh10000);

    for (ph = 0; ph < PHASES; ph++) begin
      quiet = (ph % 4 == 2);
      set_order(ph < 11 ? ORD_W'(order_plan[ph]) : ORD_W'($urandom_range(0, 15)));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain();
        send_point(pick_point(order_reg));
      end
    end
    quiet = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    failures = sb.mismatches;
    if (sb.pending() != 0) begin
      $display("%0d expected results never arrived", sb.pending());
      failures = failures + sb.pending();
    end
    $display("checked %0d spline values from %0d points, %0d mismatches",
             sb.checked, sb.accepted, sb.mismatches);
    $display("order settings written (bit per value 15..0): %b", orders_written);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
